[rtl/pfrl_pkg.sv]
// ----------------------------------------------------------------------------
// pfrl_pkg
// Shared sizes, state codes and control structs for root labeling.
// ----------------------------------------------------------------------------
package pfrl_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int MAX_PASSES = 8;

    localparam int IDX_W  = 6;
    localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
    localparam int PASS_W = $clog2(MAX_PASSES + 1);

    typedef enum logic [4:0] {
        ST_LOAD     = 5'b00001,
        ST_PASS     = 5'b00010,
        ST_DRAIN    = 5'b00100,
        ST_EMIT_RD  = 5'b01000,
        ST_EMIT_OUT = 5'b10000
    } state_t;

    typedef struct packed {
        logic             issue;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
        logic             clear_bad;
    } jump_ctl_t;

    typedef struct packed {
        logic busy;
        logic changed;
        logic bad;
    } jump_stat_t;

endpackage

[rtl/pfrl_ram.sv]
// ----------------------------------------------------------------------------
// pfrl_ram
// Label memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pfrl_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

[rtl/pfrl_jump.sv]
// ----------------------------------------------------------------------------
// pfrl_jump
// Pointer-jump pipeline: reads label[i], then label[label[i]], writes the
// new label into the other bank. Out-of-range parents become roots.
// ----------------------------------------------------------------------------
module pfrl_jump (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pfrl_pkg::jump_ctl_t       ctl,
    input  logic [pfrl_pkg::IDX_W-1:0] rdata_a,
    input  logic [pfrl_pkg::IDX_W-1:0] rdata_b,
    output logic [pfrl_pkg::IDX_W-1:0] raddr_b,
    output logic                      we,
    output logic [pfrl_pkg::IDX_W-1:0] waddr,
    output logic [pfrl_pkg::IDX_W-1:0] wdata,
    output pfrl_pkg::jump_stat_t      stat
);
    import pfrl_pkg::*;

    logic             s1_valid_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_valid_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [IDX_W-1:0] s2_cur_reg;
    logic             changed_reg, changed_next;
    logic             bad_reg, bad_next;

    logic             cur_oob;
    logic [IDX_W-1:0] cur;
    logic             nxt_oob;
    logic [IDX_W-1:0] nxt;

    always_comb begin
        cur_oob = {1'b0, rdata_a} >= ctl.count;
        cur     = cur_oob ? s1_idx_reg : rdata_a;
        nxt_oob = {1'b0, rdata_b} >= ctl.count;
        nxt     = nxt_oob ? s2_cur_reg : rdata_b;
    end

    assign raddr_b = cur;
    assign we      = s2_valid_reg;
    assign waddr   = s2_idx_reg;
    assign wdata   = nxt;

    always_comb begin
        changed_next = changed_reg;
        if (ctl.issue && ctl.idx == '0) begin
            changed_next = 1'b0;
        end
        if (s2_valid_reg && nxt != s2_cur_reg) begin
            changed_next = 1'b1;
        end
        bad_next = bad_reg;
        if (ctl.clear_bad) begin
            bad_next = 1'b0;
        end
        if (s1_valid_reg && cur_oob) begin
            bad_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            changed_reg  <= 1'b0;
            bad_reg      <= 1'b0;
        end else begin
            s1_valid_reg <= ctl.issue;
            s2_valid_reg <= s1_valid_reg;
            changed_reg  <= changed_next;
            bad_reg      <= bad_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_idx_reg <= ctl.idx;
        s2_idx_reg <= s1_idx_reg;
        s2_cur_reg <= cur;
    end

    assign stat.busy    = s1_valid_reg | s2_valid_reg;
    assign stat.changed = changed_reg;
    assign stat.bad     = bad_reg;

endmodule

[rtl/parent_forest_root_labeling.sv]
// ----------------------------------------------------------------------------
// parent_forest_root_labeling
// Loads a parent array, resolves every pixel to its tree root by pointer
// jumping over two label banks, then emits the labels in pixel order.
// ----------------------------------------------------------------------------
// Items load at one per cycle into label bank 0. The item with is_last high,
// or the 64th item, starts the passes. Each pass streams all N labels
// through a two-read pipeline (label, then label of label) from one bank
// into the other; passes repeat until one changes nothing, at most 8.
// Results then leave one at a time (EMIT_RD, then EMIT_OUT until m_ready),
// the last one carrying last_label. No item is accepted from the end of
// loading until the last result is taken. not_converged and bad_parent
// are the same on every result of one array.
// ----------------------------------------------------------------------------
module parent_forest_root_labeling (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [pfrl_pkg::IDX_W-1:0] s_parent_index,
    input  logic                      s_is_last,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [pfrl_pkg::IDX_W-1:0] m_root_label,
    output logic                      m_last_label,
    output logic                      m_not_converged,
    output logic                      m_bad_parent
);
    import pfrl_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic              src_sel_reg, src_sel_next;

    jump_ctl_t         jctl;
    jump_stat_t        jstat;

    logic [IDX_W-1:0]  rd_a0, rd_a1, rd_b0, rd_b1;
    logic [IDX_W-1:0]  src_a, src_b;
    logic [IDX_W-1:0]  raddr_b;
    logic              j_we;
    logic [IDX_W-1:0]  j_waddr, j_wdata;

    logic              we0, we1;
    logic [IDX_W-1:0]  waddr0;
    logic [IDX_W-1:0]  wdata0;
    logic              load_acc;
    logic              idx_at_end;
    logic [CNT_W-1:0]  cnt_inc;
    logic [PASS_W-1:0] pass_inc;

    assign s_ready  = state_reg == ST_LOAD;
    assign load_acc = s_valid && s_ready;
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign pass_inc = pass_reg + PASS_W'(1);
    assign idx_at_end = ({1'b0, idx_reg} + CNT_W'(1)) == cnt_reg;

    assign src_a = src_sel_reg ? rd_a1 : rd_a0;
    assign src_b = src_sel_reg ? rd_b1 : rd_b0;

    assign jctl.issue     = state_reg == ST_PASS;
    assign jctl.idx       = idx_reg;
    assign jctl.count     = cnt_reg;
    assign jctl.clear_bad = (state_reg == ST_EMIT_OUT) && m_ready && idx_at_end;

    // Bank 0 takes loads and odd-pass results; bank 1 takes even-pass results (passes counted from 0).
    assign we0    = load_acc || (j_we && src_sel_reg);
    assign waddr0 = load_acc ? cnt_reg[IDX_W-1:0] : j_waddr;
    assign wdata0 = load_acc ? s_parent_index : j_wdata;
    assign we1    = j_we && !src_sel_reg;

    pfrl_ram #(.DEPTH(MAX_PIXELS), .WIDTH(IDX_W)) u_bank0 (
        .aclk    (aclk),
        .we      (we0),
        .waddr   (waddr0),
        .wdata   (wdata0),
        .raddr_a (idx_reg),
        .rdata_a (rd_a0),
        .raddr_b (raddr_b),
        .rdata_b (rd_b0)
    );

    pfrl_ram #(.DEPTH(MAX_PIXELS), .WIDTH(IDX_W)) u_bank1 (
        .aclk    (aclk),
        .we      (we1),
        .waddr   (j_waddr),
        .wdata   (j_wdata),
        .raddr_a (idx_reg),
        .rdata_a (rd_a1),
        .raddr_b (raddr_b),
        .rdata_b (rd_b1)
    );

    pfrl_jump u_jump (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (jctl),
        .rdata_a (src_a),
        .rdata_b (src_b),
        .raddr_b (raddr_b),
        .we      (j_we),
        .waddr   (j_waddr),
        .wdata   (j_wdata),
        .stat    (jstat)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        pass_next    = pass_reg;
        src_sel_next = src_sel_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (load_acc) begin
                    cnt_next = cnt_inc;
                    if (s_is_last || cnt_inc == CNT_W'(MAX_PIXELS)) begin
                        state_next   = ST_PASS;
                        idx_next     = '0;
                        pass_next    = '0;
                        src_sel_next = 1'b0;
                    end
                end
            end
            ST_PASS: begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_at_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!jstat.busy) begin
                    pass_next    = pass_inc;
                    src_sel_next = !src_sel_reg;
                    idx_next     = '0;
                    if (jstat.changed && pass_inc < PASS_W'(MAX_PASSES)) begin
                        state_next = ST_PASS;
                    end else begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_OUT;
            end
            ST_EMIT_OUT: begin
                if (m_ready) begin
                    if (idx_at_end) begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                        pass_next  = '0;
                        idx_next   = '0;
                    end else begin
                        state_next = ST_EMIT_RD;
                        idx_next   = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            pass_reg    <= '0;
            src_sel_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            pass_reg    <= pass_next;
            src_sel_reg <= src_sel_next;
        end
    end

    assign m_valid         = state_reg == ST_EMIT_OUT;
    assign m_root_label    = src_a;
    assign m_last_label    = idx_at_end;
    assign m_not_converged = jstat.changed;
    assign m_bad_parent    = jstat.bad;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Sends parent arrays to parent_forest_root_labeling under varied flow
// control. For each array it resolves the roots independently by synchronous
// pointer jumping and checks every label, marker and flag in order.
// ----------------------------------------------------------------------------
module tb;
    import pfrl_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 64;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct {
        int   pixel;
        idx_t root_label;
        logic last_label;
        logic not_converged;
        logic bad_parent;
    } label_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    idx_t s_parent_index = '0;
    logic s_is_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    idx_t m_root_label;
    logic m_last_label;
    logic m_not_converged;
    logic m_bad_parent;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int items_sent = 0;

    idx_t          pending_parents [$];
    label_result_t expected_labels [$];

    parent_forest_root_labeling dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_parent_index  (s_parent_index),
        .s_is_last       (s_is_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_root_label    (m_root_label),
        .m_last_label    (m_last_label),
        .m_not_converged (m_not_converged),
        .m_bad_parent    (m_bad_parent)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void resolve_roots();
        int            n;
        int            passes;
        logic          bad;
        logic          changed;
        idx_t          cur_lbl [MAX_PIXELS];
        idx_t          nxt_lbl [MAX_PIXELS];
        label_result_t r;
        n = pending_parents.size();
        bad = 1'b0;
        for (int i = 0; i < n; i++) begin
            if (pending_parents[i] >= n) begin
                cur_lbl[i] = idx_t'(i);
                bad = 1'b1;
            end else begin
                cur_lbl[i] = pending_parents[i];
            end
        end
        changed = 1'b1;
        passes = 0;
        while (changed && passes < MAX_PASSES) begin
            changed = 1'b0;
            for (int i = 0; i < n; i++) begin
                nxt_lbl[i] = cur_lbl[cur_lbl[i]];
                if (nxt_lbl[i] != cur_lbl[i])
                    changed = 1'b1;
            end
            for (int i = 0; i < n; i++)
                cur_lbl[i] = nxt_lbl[i];
            passes++;
        end
        for (int i = 0; i < n; i++) begin
            r.pixel = i;
            r.root_label = cur_lbl[i];
            r.last_label = (i == n - 1);
            r.not_converged = changed;
            r.bad_parent = bad;
            expected_labels.push_back(r);
        end
        pending_parents.delete();
    endfunction

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_pixel(input idx_t parent, input logic last);
        int gap;
        s_valid <= 1'b1;
        s_parent_index <= parent;
        s_is_last <= last;
        do @(posedge aclk); while (!s_ready);
        pending_parents.push_back(parent);
        if (last || pending_parents.size() == MAX_PIXELS)
            resolve_roots();
        items_sent++;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_labels.size() != 0)
            @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic send_array(input idx_t parents [$]);
        foreach (parents[i])
            send_pixel(parents[i], i == parents.size() - 1);
    endtask

    always @(posedge aclk) begin
        label_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_labels.size() == 0) begin
                $display("%0t: unexpected result root_label %0d last_label %0b",
                         $time, m_root_label, m_last_label);
                mismatches++;
            end else begin
                want = expected_labels.pop_front();
                if (m_root_label !== want.root_label) begin
                    $display("%0t: pixel %0d root_label expected %0d actual %0d",
                             $time, want.pixel, want.root_label, m_root_label);
                    mismatches++;
                end
                if (m_last_label !== want.last_label) begin
                    $display("%0t: pixel %0d last_label expected %0b actual %0b",
                             $time, want.pixel, want.last_label, m_last_label);
                    mismatches++;
                end
                if (m_not_converged !== want.not_converged) begin
                    $display("%0t: pixel %0d not_converged expected %0b actual %0b",
                             $time, want.pixel, want.not_converged, m_not_converged);
                    mismatches++;
                end
                if (m_bad_parent !== want.bad_parent) begin
                    $display("%0t: pixel %0d bad_parent expected %0b actual %0b",
                             $time, want.pixel, want.bad_parent, m_bad_parent);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_single_pixel();
        set_idling(0, 0);
        send_pixel(6'd0, 1'b1);
        send_pixel(6'd63, 1'b1);
        send_pixel(6'd1, 1'b1);
        drain_results();
    endtask

    task automatic test_small_forests();
        set_idling(78, 78);
        send_array('{6'd0, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd4, 6'd7, 6'd7});
        send_array('{6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd5});
        drain_results();
        // out-of-range parent becomes its own root
        send_array('{6'd2, 6'd1, 6'd40, 6'd0});
        // cycles never settle
        send_array('{6'd1, 6'd0});
        send_array('{6'd1, 6'd2, 6'd0});
        drain_results();
    endtask

    task automatic test_full_arrays();
        set_idling(6, 6);
        // long chain with no end marker: 64th item closes the array
        for (int i = 0; i < MAX_PIXELS; i++)
            send_pixel(idx_t'(i == 0 ? 0 : i - 1), 1'b0);
        drain_results();
    endtask

    task automatic test_random_arrays();
        int   start;
        int   n;
        int   kind;
        idx_t parent;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case (((items_sent - start) * 4) / RANDOM_ITEMS)
                0: set_idling(0, 0);
                1: set_idling(78, 0);
                2: set_idling(0, 78);
                default: set_idling(6, 6);
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
            kind = $urandom_range(99);
            for (int i = 0; i < n; i++) begin
                if (kind < 70)
                    parent = idx_t'($urandom_range(i, 0));
                else if (kind < 85)
                    parent = idx_t'($urandom_range(n - 1, 0));
                else
                    parent = idx_t'($urandom_range(63, 0));
                send_pixel(parent, i == n - 1);
            end
            if ($urandom_range(7) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_pixel();
        test_small_forests();
        test_full_arrays();
        test_random_arrays();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
